### src/esds_pkg.sv
`default_nettype none

package esds_pkg;

    // parser phases
    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_SIZE    = 3'd1;
    localparam logic [2:0] PH_SKIP    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_SHORT     = 2'd2;

    // descriptor tags
    localparam logic [7:0] TAG_ES_DESCR   = 8'd3;
    localparam logic [7:0] TAG_DEC_CONFIG = 8'd4;
    localparam logic [7:0] TAG_DEC_SPEC   = 8'd5;

    // fixed skip lengths of the es and decoder config descriptors
    localparam logic [31:0] ES_DESCR_SKIP   = 32'd3;
    localparam logic [31:0] DEC_CONFIG_SKIP = 32'd13;

    localparam logic [3:0] IDX_EXPLICIT = 4'd15;
    localparam int unsigned HEAD_BYTES  = 5;

    typedef struct packed {
        logic [4:0]  object_type;
        logic [3:0]  rate_index;
        logic [23:0] sample_rate;
        logic [3:0]  chan_cfg;
        logic        too_short;
    } decoded_t;

    function automatic logic [23:0] rate_lookup(input logic [3:0] idx);
        logic [23:0] rate;
        case (idx)
            4'd0:    rate = 24'd96000;
            4'd1:    rate = 24'd88200;
            4'd2:    rate = 24'd64000;
            4'd3:    rate = 24'd48000;
            4'd4:    rate = 24'd44100;
            4'd5:    rate = 24'd32000;
            4'd6:    rate = 24'd24000;
            4'd7:    rate = 24'd22050;
            4'd8:    rate = 24'd16000;
            4'd9:    rate = 24'd12000;
            4'd10:   rate = 24'd11025;
            4'd11:   rate = 24'd8000;
            4'd12:   rate = 24'd7350;
            default: rate = 24'd0;
        endcase
        return rate;
    endfunction

endpackage

`default_nettype wire

### src/esds_cfg_decode.sv
`default_nettype none

module esds_cfg_decode
(
    input  wire logic [39:0]       head_bits,
    input  wire logic [2:0]        head_count,
    output esds_pkg::decoded_t     dec
);
    import esds_pkg::*;

    logic [39:0] aligned;
    logic [2:0]  cnt;

    // left-align the collected bytes, msb first
    always_comb
    begin
        cnt = (head_count > 3'd5) ? 3'd5 : head_count;
        case (cnt)
            3'd0:    aligned = 40'd0;
            3'd1:    aligned = {head_bits[7:0], 32'd0};
            3'd2:    aligned = {head_bits[15:0], 24'd0};
            3'd3:    aligned = {head_bits[23:0], 16'd0};
            3'd4:    aligned = {head_bits[31:0], 8'd0};
            default: aligned = head_bits;
        endcase
    end

    always_comb
    begin
        dec.object_type = aligned[39:35];
        dec.rate_index  = aligned[34:31];
        if (aligned[34:31] == IDX_EXPLICIT)
        begin
            dec.sample_rate = aligned[30:7];
            dec.chan_cfg    = aligned[6:3];
        end
        else
        begin
            dec.sample_rate = rate_lookup(aligned[34:31]);
            dec.chan_cfg    = aligned[30:27];
        end
        dec.too_short = (cnt < 3'd2) ||
                        ((aligned[34:31] == IDX_EXPLICIT) && (cnt < 3'd5));
    end

endmodule

`default_nettype wire

### src/esds_descriptor_parser.sv
`default_nettype none
// a result is loaded into the output register when its byte is accepted and shows in the next cycle
// throughput: one cookie byte per cycle; the only limit is the single output register,
// which takes a new result in the same cycle its old one is taken
// reset: rst_n clears the parser to expect a tag byte and empties the output register
// each byte flagged cookie_end also returns the parser to that reset state

module esds_descriptor_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // cookie byte requests
    input  wire logic        cookie_valid,
    output logic             cookie_ready,
    input  wire logic [7:0]  cookie_byte,
    input  wire logic        cookie_end,

    // result requests
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             final_res,
    output logic [1:0]       status,
    output logic [4:0]       object_type,
    output logic [3:0]       rate_index,
    output logic [23:0]      sample_rate,
    output logic [3:0]       chan_cfg
);
    import esds_pkg::*;

    // parser state
    logic [2:0]  phase_reg,  phase_next;
    logic [7:0]  tag_reg,    tag_next;
    logic [31:0] accum_reg,  accum_next;
    logic [31:0] remain_reg, remain_next;
    logic [39:0] head_reg,   head_next;
    logic [2:0]  count_reg,  count_next;

    // output register
    logic        res_valid_reg;
    logic [7:0]  res_byte_reg,   res_byte_next;
    logic        res_bvalid_reg, res_bvalid_next;
    logic        res_final_reg,  res_final_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [4:0]  res_obj_reg,    res_obj_next;
    logic [3:0]  res_idx_reg,    res_idx_next;
    logic [23:0] res_rate_reg,   res_rate_next;
    logic [3:0]  res_chan_reg,   res_chan_next;
    logic        res_fire;

    logic        accept;
    logic [31:0] accum_new;
    logic [31:0] size_val;
    logic [39:0] head_upd;
    logic [2:0]  count_upd;
    decoded_t    dec;

    // output register can load whenever it is empty or being drained
    assign cookie_ready = !res_valid_reg || result_ready;
    assign accept       = cookie_valid && cookie_ready;

    // collect up to five leading config bytes
    always_comb
    begin
        if (count_reg < 3'(HEAD_BYTES))
        begin
            head_upd  = {head_reg[31:0], cookie_byte};
            count_upd = count_reg + 3'd1;
        end
        else
        begin
            head_upd  = head_reg;
            count_upd = count_reg;
        end
    end

    // decode sees the head including the byte in hand
    esds_cfg_decode u_decode
    (
        .head_bits  (head_upd),
        .head_count (count_upd),
        .dec        (dec)
    );

    // size field: 7 bits per byte, msb is continuation, low 32 bits kept
    assign accum_new = {accum_reg[24:0], cookie_byte[6:0]};

    always_comb
    begin
        if (tag_reg == TAG_ES_DESCR)
            size_val = ES_DESCR_SKIP;
        else if (tag_reg == TAG_DEC_CONFIG)
            size_val = DEC_CONFIG_SKIP;
        else
            size_val = accum_new;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        accum_next  = accum_reg;
        remain_next = remain_reg;
        head_next   = head_reg;
        count_next  = count_reg;

        res_fire        = 1'b0;
        res_byte_next   = 8'd0;
        res_bvalid_next = 1'b0;
        res_final_next  = 1'b0;
        res_status_next = ST_OK;
        res_obj_next    = 5'd0;
        res_idx_next    = 4'd0;
        res_rate_next   = 24'd0;
        res_chan_next   = 4'd0;

        unique case (phase_reg)
            PH_TAG:
            begin
                tag_next   = cookie_byte;
                accum_next = 32'd0;
                phase_next = PH_SIZE;
            end
            PH_SIZE:
            begin
                accum_next = accum_new;
                if (!cookie_byte[7])
                begin
                    remain_next = size_val;
                    if (tag_reg == TAG_DEC_SPEC)
                    begin
                        head_next  = 40'd0;
                        count_next = 3'd0;
                        if (size_val == 32'd0)
                        begin
                            // empty config descriptor
                            res_fire        = 1'b1;
                            res_final_next  = 1'b1;
                            res_status_next = ST_SHORT;
                            phase_next      = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        phase_next = (size_val == 32'd0) ? PH_TAG : PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                    phase_next = PH_TAG;
            end
            PH_PAYLOAD:
            begin
                head_next       = head_upd;
                count_next      = count_upd;
                remain_next     = remain_reg - 32'd1;
                res_fire        = 1'b1;
                res_byte_next   = cookie_byte;
                res_bvalid_next = 1'b1;
                if (remain_reg == 32'd1)
                begin
                    // last config byte: attach the decoded fields
                    res_final_next = 1'b1;
                    phase_next     = PH_DONE;
                    if (dec.too_short)
                    begin
                        res_status_next = ST_SHORT;
                    end
                    else
                    begin
                        res_obj_next  = dec.object_type;
                        res_idx_next  = dec.rate_index;
                        res_rate_next = dec.sample_rate;
                        res_chan_next = dec.chan_cfg;
                    end
                end
                else if (cookie_end)
                begin
                    // cookie cut off inside the config payload
                    res_final_next  = 1'b1;
                    res_status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                // config already delivered: trailing bytes are dropped
            end
        endcase

        if (cookie_end)
        begin
            if (!res_fire && (phase_next != PH_DONE))
            begin
                res_fire        = 1'b1;
                res_final_next  = 1'b1;
                res_status_next = ST_NOT_FOUND;
            end
            phase_next  = PH_TAG;
            tag_next    = 8'd0;
            accum_next  = 32'd0;
            remain_next = 32'd0;
            head_next   = 40'd0;
            count_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            tag_reg    <= 8'd0;
            accum_reg  <= 32'd0;
            remain_reg <= 32'd0;
            head_reg   <= 40'd0;
            count_reg  <= 3'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            accum_reg  <= accum_next;
            remain_reg <= remain_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
        end
    end

    // output valid: set by a byte that produces a result, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= res_fire;
        else if (result_ready)
            res_valid_reg <= 1'b0;
    end

    // result payload, loaded only when a new result is produced
    always_ff @(posedge clk)
    begin
        if (accept && res_fire)
        begin
            res_byte_reg   <= res_byte_next;
            res_bvalid_reg <= res_bvalid_next;
            res_final_reg  <= res_final_next;
            res_status_reg <= res_status_next;
            res_obj_reg    <= res_obj_next;
            res_idx_reg    <= res_idx_next;
            res_rate_reg   <= res_rate_next;
            res_chan_reg   <= res_chan_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign payload_byte = res_byte_reg;
    assign byte_valid   = res_bvalid_reg;
    assign final_res    = res_final_reg;
    assign status       = res_status_reg;
    assign object_type  = res_obj_reg;
    assign rate_index   = res_idx_reg;
    assign sample_rate  = res_rate_reg;
    assign chan_cfg     = res_chan_reg;

`ifndef SYNTH
    // a cookie_end byte always leaves the parser in its reset state
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cookie_end) |=> (phase_reg == PH_TAG) && (count_reg == 3'd0)
            && (remain_reg == 32'd0))
        else $error("parser not reset after cookie end");

    // the head collector never holds more than five bytes
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(HEAD_BYTES))
        else $error("head byte count overflow");

    // a non-final result always carries status ok
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !final_res) |-> (status == ST_OK))
        else $error("status set on non-final result");

    // decoded fields stay zero unless a good final result
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !(final_res && (status == ST_OK)))
            |-> (object_type == 5'd0) && (rate_index == 4'd0)
                && (sample_rate == 24'd0) && (chan_cfg == 4'd0))
        else $error("decoded fields set on wrong result");

    // a good final result is always a config byte
    a_ok_final_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_res && (status == ST_OK)) |-> byte_valid)
        else $error("ok final result without config byte");
`endif

endmodule

`default_nettype wire
